// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the tilt angle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked assertion that is switched off while reset is active.
`define ATL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Clocked assertion that also holds while reset is active.
`define ATL_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ATL_ASSERT(name, clk, rst_n, prop)
`define ATL_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ===== design/atl_pkg.sv =====
// Types, constants and step functions of the tilt angle pipeline.
`timescale 1ns / 1ps
`default_nettype none
package atl_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned TabLen = 24;
  localparam int unsigned AxW = 16;
  localparam int unsigned OffW = 15;
  localparam int unsigned OutW = 16;
  localparam int unsigned SqW = 32;
  localparam int unsigned RadW = 48;
  localparam int unsigned RootW = 24;
  localparam int unsigned RemW = 27;
  localparam int unsigned CW = 27;
  localparam int unsigned ZW = 25;
  localparam int unsigned SqrtSteps = RadW / 2;
  localparam int signed Deg180 = 2949120;
  localparam int signed OutLimit = 23040;
  localparam int signed RoundHalf = 128;

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_OFFSET_Z = 2'd2
  } reg_idx_e;

  typedef logic signed [AxW-1:0] axis_t;
  typedef logic signed [OffW-1:0] off_t;
  typedef logic signed [OutW-1:0] tilt_t;

  // One square root in progress.
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  rad;
  } sqs_t;

  // One vectoring CORDIC in progress.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 fixed;
  } cst_t;

  // Arctangent of 2^-i in 1/16384 degree.
  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] v;
    begin
      case (i)
        0: v = 25'sd737280;
        1: v = 25'sd435242;
        2: v = 25'sd229970;
        3: v = 25'sd116736;
        4: v = 25'sd58595;
        5: v = 25'sd29326;
        6: v = 25'sd14667;
        7: v = 25'sd7334;
        8: v = 25'sd3667;
        9: v = 25'sd1833;
        10: v = 25'sd917;
        11: v = 25'sd458;
        12: v = 25'sd229;
        13: v = 25'sd115;
        14: v = 25'sd57;
        15: v = 25'sd29;
        16: v = 25'sd14;
        17: v = 25'sd7;
        18: v = 25'sd4;
        19: v = 25'sd2;
        20: v = 25'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // Start a square root of sum * 65536.
  function automatic sqs_t sqrt_init(input logic [SqW-1:0] sum);
    sqs_t s;
    begin
      s.rem  = '0;
      s.root = '0;
      s.rad  = {sum, {(RadW-SqW){1'b0}}};
      return s;
    end
  endfunction

  // One digit of the restoring square root.
  function automatic sqs_t sqrt_step(input sqs_t s);
    sqs_t             n;
    logic [RemW-1:0]  rem2;
    logic [RemW-1:0]  trial;
    begin
      rem2  = {s.rem[RemW-3:0], s.rad[RadW-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      n.rad = {s.rad[RadW-3:0], 2'b00};
      if (rem2 >= trial) begin
        n.rem  = rem2 - trial;
        n.root = {s.root[RootW-2:0], 1'b1};
      end else begin
        n.rem  = rem2;
        n.root = {s.root[RootW-2:0], 1'b0};
      end
      return n;
    end
  endfunction

  // Fold the operands into the right half plane and mark the zero case.
  function automatic cst_t cordic_prep(input logic signed [CW-1:0] y,
                                       input logic signed [CW-1:0] x);
    cst_t c;
    begin
      c.x     = x;
      c.y     = y;
      c.z     = '0;
      c.fixed = 1'b0;
      if (y == '0) begin
        c.fixed = 1'b1;
        if (x < 0) begin
          c.z = ZW'(Deg180);
        end
      end else if (x < 0) begin
        c.x = -x;
        c.y = -y;
        c.z = (y > 0) ? ZW'(Deg180) : ZW'(-Deg180);
      end
      return c;
    end
  endfunction

  // One vectoring rotation with a fixed shift.
  function automatic cst_t cordic_step(input cst_t c, input int unsigned i);
    cst_t                 n;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    begin
      xs = c.x >>> i;
      ys = c.y >>> i;
      n  = c;
      if (!c.fixed) begin
        if (c.y >= 0) begin
          n.x = c.x + ys;
          n.y = c.y - xs;
          n.z = c.z + atan_tab(i);
        end else begin
          n.x = c.x - ys;
          n.y = c.y + xs;
          n.z = c.z - atan_tab(i);
        end
      end
      return n;
    end
  endfunction

  // Round to 1/64 degree, add the offset and saturate.
  function automatic tilt_t finish(input logic signed [ZW-1:0] z, input off_t off);
    logic signed [ZW:0]   zr;
    logic signed [ZW:0]   sum;
    begin
      zr  = (ZW+1)'(z) + (ZW+1)'(RoundHalf);
      sum = (zr >>> 8) + (ZW+1)'(off);
      if (sum > (ZW+1)'(OutLimit)) begin
        sum = (ZW+1)'(OutLimit);
      end else if (sum < (ZW+1)'(-OutLimit)) begin
        sum = (ZW+1)'(-OutLimit);
      end
      return sum[OutW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/atl_intf.sv =====
// Channel interfaces: sample input, tilt output and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface atl_sample_if;
  logic          valid;
  logic          ready;
  atl_pkg::axis_t accel_x;
  atl_pkg::axis_t accel_y;
  atl_pkg::axis_t accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atl_tilt_if;
  logic          valid;
  logic          ready;
  atl_pkg::tilt_t tilt_x;
  atl_pkg::tilt_t tilt_y;
  atl_pkg::tilt_t tilt_z;
  modport source (output valid, tilt_x, tilt_y, tilt_z, input ready);
  modport sink (input valid, tilt_x, tilt_y, tilt_z, output ready);
endinterface

interface atl_cfg_if;
  logic         valid;
  logic         ready;
  logic [1:0]   index;
  atl_pkg::off_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/atl_flow.sv =====
// Valid bits and load enables of the pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module atl_flow #(
  parameter int unsigned NumStages = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  output logic [NumStages-1:0] en_o,
  output logic [NumStages-1:0] vld_o
);

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_d;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    en_o[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en_o[k] = !vld_q[k] || en_o[k+1];
    end
  end

  // Valid bits follow the data.
  always_comb begin
    vld_d = vld_q;
    if (en_o[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en_o[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign vld_o = vld_q;

  `ATL_ASSERT(a_out_held, clk_i, rst_ni, vld_q[NumStages-1] && !out_ready_i |=> vld_q[NumStages-1])
  `ATL_ASSERT(a_ready_on_drain, clk_i, rst_ni, out_ready_i |-> en_o[0])
  `ATL_ASSERT(a_ready_when_empty, clk_i, rst_ni, !vld_q[NumStages-1] |-> en_o[0])
  `ATL_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> vld_q == '0 || rst_ni)

endmodule
`default_nettype wire

// ===== design/accel_tilt_angles.sv =====
// Top level: three tilt angles from one accelerometer sample.
//
// Channel   Dir   Fields                       Transfer when
// sample_i  in    accel_x, accel_y, accel_z    valid && ready
// tilt_o    out   tilt_x, tilt_y, tilt_z       valid && ready
// cfg_i     in    index, data (offset)         valid && ready (always ready)
//
// One sample enters per cycle unless a stall at the output holds the first stage;
// each result passes through the two square and sum stages, the 24 square root
// digit stages, the fold stage and one CORDIC stage for each of the
// min(CORDIC_STEPS, 24) rotations ahead of the output register. Reset clears all
// valid bits and loads the offset reset values. A stall at the output holds every
// full stage that has no empty stage after it, while empty stages keep filling.
`timescale 1ns / 1ps
`default_nettype none
module accel_tilt_angles #(
  parameter int unsigned CORDIC_STEPS = atl_pkg::CordicStepsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  atl_sample_if.sink        sample_i,
  atl_tilt_if.source        tilt_o,
  atl_cfg_if.sink           cfg_i
);

  localparam int unsigned NumRot =
      (CORDIC_STEPS > atl_pkg::TabLen) ? atl_pkg::TabLen : CORDIC_STEPS;
  localparam int unsigned SqBase = 2;
  localparam int unsigned PrepIdx = SqBase + atl_pkg::SqrtSteps;
  localparam int unsigned RotBase = PrepIdx + 1;
  localparam int unsigned OutIdx = RotBase + NumRot;
  localparam int unsigned NumStages = OutIdx + 1;

  logic [NumStages-1:0] en;
  logic [NumStages-1:0] vld;

  atl_flow #(.NumStages(NumStages)) u_flow (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .out_ready_i(tilt_o.ready),
    .en_o       (en),
    .vld_o      (vld)
  );

  assign sample_i.ready = en[0];

  // Offset registers.
  atl_pkg::off_t off_q [3];
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0] <= atl_pkg::off_t'(-1920);
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        atl_pkg::REG_OFFSET_X: off_q[0] <= cfg_i.data;
        atl_pkg::REG_OFFSET_Y: off_q[1] <= cfg_i.data;
        atl_pkg::REG_OFFSET_Z: off_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Stage 0: squares of the axes.
  atl_pkg::axis_t                ax0_q, ay0_q, az0_q;
  logic signed [atl_pkg::SqW-1:0] sqx_q, sqy_q, sqz_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ax0_q <= sample_i.accel_x;
      ay0_q <= sample_i.accel_y;
      az0_q <= sample_i.accel_z;
      sqx_q <= sample_i.accel_x * sample_i.accel_x;
      sqy_q <= sample_i.accel_y * sample_i.accel_y;
      sqz_q <= sample_i.accel_z * sample_i.accel_z;
    end
  end

  // Stage 1: sums of pairs of squares.
  atl_pkg::axis_t           ax1_q, ay1_q, az1_q;
  logic [atl_pkg::SqW-1:0]  syz_q, sxz_q, sxy_q;
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ax1_q <= ax0_q;
      ay1_q <= ay0_q;
      az1_q <= az0_q;
      syz_q <= sqy_q + sqz_q;
      sxz_q <= sqx_q + sqz_q;
      sxy_q <= sqx_q + sqy_q;
    end
  end

  // Square root stages, one digit each for all three hypotenuses.
  atl_pkg::sqs_t  hyz_q [atl_pkg::SqrtSteps];
  atl_pkg::sqs_t  hxz_q [atl_pkg::SqrtSteps];
  atl_pkg::sqs_t  hxy_q [atl_pkg::SqrtSteps];
  atl_pkg::axis_t sax_q [atl_pkg::SqrtSteps];
  atl_pkg::axis_t say_q [atl_pkg::SqrtSteps];
  atl_pkg::axis_t saz_q [atl_pkg::SqrtSteps];

  for (genvar j = 0; j < atl_pkg::SqrtSteps; j++) begin : g_sqrt
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[SqBase]) begin
          hyz_q[0] <= atl_pkg::sqrt_step(atl_pkg::sqrt_init(syz_q));
          hxz_q[0] <= atl_pkg::sqrt_step(atl_pkg::sqrt_init(sxz_q));
          hxy_q[0] <= atl_pkg::sqrt_step(atl_pkg::sqrt_init(sxy_q));
          sax_q[0] <= ax1_q;
          say_q[0] <= ay1_q;
          saz_q[0] <= az1_q;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[SqBase+j]) begin
          hyz_q[j] <= atl_pkg::sqrt_step(hyz_q[j-1]);
          hxz_q[j] <= atl_pkg::sqrt_step(hxz_q[j-1]);
          hxy_q[j] <= atl_pkg::sqrt_step(hxy_q[j-1]);
          sax_q[j] <= sax_q[j-1];
          say_q[j] <= say_q[j-1];
          saz_q[j] <= saz_q[j-1];
        end
      end
    end
  end

  // Operands of the three arctangents at 8 fraction bits.
  logic signed [atl_pkg::CW-1:0] fx, fy, fz, hyz, hxz, hxy;
  assign fx  = {{(atl_pkg::CW-atl_pkg::AxW-8){sax_q[atl_pkg::SqrtSteps-1][atl_pkg::AxW-1]}},
                sax_q[atl_pkg::SqrtSteps-1], 8'd0};
  assign fy  = {{(atl_pkg::CW-atl_pkg::AxW-8){say_q[atl_pkg::SqrtSteps-1][atl_pkg::AxW-1]}},
                say_q[atl_pkg::SqrtSteps-1], 8'd0};
  assign fz  = {{(atl_pkg::CW-atl_pkg::AxW-8){saz_q[atl_pkg::SqrtSteps-1][atl_pkg::AxW-1]}},
                saz_q[atl_pkg::SqrtSteps-1], 8'd0};
  assign hyz = {{(atl_pkg::CW-atl_pkg::RootW){1'b0}}, hyz_q[atl_pkg::SqrtSteps-1].root};
  assign hxz = {{(atl_pkg::CW-atl_pkg::RootW){1'b0}}, hxz_q[atl_pkg::SqrtSteps-1].root};
  assign hxy = {{(atl_pkg::CW-atl_pkg::RootW){1'b0}}, hxy_q[atl_pkg::SqrtSteps-1].root};

  // Prepare stage: half plane folding and the zero case.
  atl_pkg::cst_t prx_q, pry_q, prz_q;
  always_ff @(posedge clk_i) begin
    if (en[PrepIdx]) begin
      prx_q <= atl_pkg::cordic_prep(fx, hyz);
      pry_q <= atl_pkg::cordic_prep(fy, hxz);
      prz_q <= atl_pkg::cordic_prep(hxy, fz);
    end
  end

  // CORDIC stages, one rotation each.
  atl_pkg::cst_t crx_q [NumRot];
  atl_pkg::cst_t cry_q [NumRot];
  atl_pkg::cst_t crz_q [NumRot];

  for (genvar i = 0; i < NumRot; i++) begin : g_rot
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[RotBase]) begin
          crx_q[0] <= atl_pkg::cordic_step(prx_q, 0);
          cry_q[0] <= atl_pkg::cordic_step(pry_q, 0);
          crz_q[0] <= atl_pkg::cordic_step(prz_q, 0);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[RotBase+i]) begin
          crx_q[i] <= atl_pkg::cordic_step(crx_q[i-1], i);
          cry_q[i] <= atl_pkg::cordic_step(cry_q[i-1], i);
          crz_q[i] <= atl_pkg::cordic_step(crz_q[i-1], i);
        end
      end
    end
  end

  // Output register: rounding, offset and saturation.
  atl_pkg::tilt_t tx_q, ty_q, tz_q;
  always_ff @(posedge clk_i) begin
    if (en[OutIdx]) begin
      tx_q <= atl_pkg::finish(crx_q[NumRot-1].z, off_q[0]);
      ty_q <= atl_pkg::finish(cry_q[NumRot-1].z, off_q[1]);
      tz_q <= atl_pkg::finish(crz_q[NumRot-1].z, off_q[2]);
    end
  end

  assign tilt_o.valid  = vld[OutIdx];
  assign tilt_o.tilt_x = tx_q;
  assign tilt_o.tilt_y = ty_q;
  assign tilt_o.tilt_z = tz_q;

endmodule
`default_nettype wire
